@@ design/assert_macros.svh @@
// shared assertion macros, clocked on clk with asynchronous active-low arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define TLI_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// condition must never be seen outside reset
`define TLI_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

@@ design/tli_pkg.sv @@
`default_nettype none

package tli_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	// field widths
	localparam int X_W = 24;
	localparam int Y_W = 16;
	localparam int IDX_W = 8;
	localparam int LEN_W = 8;

	// derived datapath widths
	localparam int DX_W = X_W + 1;
	localparam int DY_W = Y_W + 1;
	localparam int TERM_W = DY_W + 1;
	localparam int PROD_W = DX_W + TERM_W;

	localparam logic [LEN_W-1:0] TABLE_LENGTH_RST = 8'd140;
	localparam int MIN_LENGTH = 2;

	localparam int TEMP_POS_LIMIT = 32767;
	localparam int TEMP_NEG_LIMIT = 32768;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CONVERT = 1'b1;

	typedef struct packed {
		logic command;
		logic [IDX_W-1:0] entry_index;
		logic [X_W-1:0] entry_x;
		logic signed [Y_W-1:0] entry_y;
		logic [X_W-1:0] measured_resistance;
	} request_t;

	typedef struct packed {
		logic signed [Y_W-1:0] temperature;
		logic saturated;
	} result_t;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic signed [Y_W-1:0] y;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_SCAN,
		ST_MUL,
		ST_DIVGO,
		ST_DIV
	} tli_state_t;

endpackage

`default_nettype wire

@@ design/tli_ram.sv @@
`default_nettype none

module tli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ design/tli_div.sv @@
`default_nettype none

module tli_div #(
	parameter int NW = 43,
	parameter int DW = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NW-1:0] dividend,
	input logic [DW-1:0] divisor,
	output logic done,
	output logic [NW-1:0] quotient
);

	`include "assert_macros.svh"

	localparam int CW = $clog2(NW);

	logic run_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [DW:0] trial;
	logic [DW+1:0] diff;
	logic ge;

	// restoring step: one quotient bit per cycle, msb first
	assign trial = {rem_q, quo_q[NW-1]};
	assign diff = {1'b0, trial} - {2'b00, div_q};
	assign ge = !diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

	`TLI_ASSERT(a_div_done_pulse, done_q |=> !done_q)
	`TLI_ASSERT_NEVER(a_div_start_while_run, start && run_q)
	`TLI_ASSERT(a_div_done_after_run, done_q |-> $past(run_q))

endmodule

`default_nettype wire

@@ design/table_linear_interpolator.sv @@
// channel   | handshake                        | payload
// ----------+----------------------------------+--------------------------------
// command   | start, busy (transfer on start   | request (load entry / convert)
//           | high while busy low)             |
// result    | done, one-cycle strobe           | result (temperature, saturated)
// config    | cfg_valid, cfg_ready             | cfg_data (table_length)
//
// a load transfer writes the table in its own cycle; busy never rises
// a convert scans one table entry per cycle out of the table memory, then runs
// a bit-serial multiply and a bit-serial restoring divide; the scan covers
// entries 1 to at most 254; when the bracketing x values are equal the result
// strobes from the scan, skipping the multiply and divide
// arst_n clears control and table_length (140); table contents stay undefined
// done cannot be held off by the receiver; busy drops in the strobe cycle
`default_nettype none

module table_linear_interpolator #(
	parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input tli_pkg::request_t request,
	output logic done,
	output tli_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [tli_pkg::LEN_W-1:0] cfg_data
);

	`include "assert_macros.svh"

	localparam int AW = $clog2(TABLE_DEPTH);
	// wide enough for the entry index, table_length and TABLE_DEPTH itself
	localparam int LW = ((AW > tli_pkg::IDX_W) ? AW : tli_pkg::IDX_W) + 1;
	localparam int XW = tli_pkg::X_W;
	localparam int YW = tli_pkg::Y_W;
	localparam int DXW = tli_pkg::DX_W;
	localparam int DYW = tli_pkg::DY_W;
	localparam int TW = tli_pkg::TERM_W;
	localparam int PW = tli_pkg::PROD_W;
	localparam int EW = XW + YW;
	localparam int MUL_STEPS = DXW;
	localparam int CNT_W = $clog2(MUL_STEPS);

	// control state
	tli_pkg::tli_state_t state_q;
	tli_pkg::tli_state_t state_d;
	logic [tli_pkg::LEN_W-1:0] table_length_q;
	logic [AW-1:0] i_q;
	logic [CNT_W-1:0] bit_cnt_q;
	logic done_q;

	// datapath registers
	logic [XW-1:0] xv_q;
	logic [XW-1:0] x0_q;
	logic signed [YW-1:0] y0_q;
	logic signed [DXW-1:0] dx_q;
	logic signed [DYW-1:0] dy_q;
	logic [DXW-1:0] dx_sh_q;
	logic [DXW-1:0] xd_sh_q;
	logic signed [PW-1:0] acc_q;
	tli_pkg::result_t result_q;

	// combinational
	logic accept;
	logic [LW-1:0] len_ext;
	logic [LW-1:0] len_clamp;
	logic [LW-1:0] last_full;
	logic [AW-1:0] last_idx;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	tli_pkg::entry_t ram_wdata;
	tli_pkg::entry_t ram_rdata;
	logic scan_stop;
	logic dx_zero;
	logic signed [DXW-1:0] dx_c;
	logic signed [DXW-1:0] xd_c;
	logic signed [DYW-1:0] dy_c;
	logic signed [TW-1:0] term_y0;
	logic signed [TW-1:0] term_dy;
	logic signed [TW-1:0] term;
	logic signed [PW-1:0] acc_d;
	logic div_start;
	logic div_done;
	logic [PW-1:0] div_dividend;
	logic [XW-1:0] div_divisor;
	logic [PW-1:0] div_quotient;
	logic res_neg;
	tli_pkg::result_t res_div;

	assign accept = start && !busy;

	// last usable index: table_length clamped to 2..TABLE_DEPTH, minus one
	always_comb begin
		len_ext = LW'(table_length_q);
		if (len_ext < LW'(tli_pkg::MIN_LENGTH)) begin
			len_clamp = LW'(tli_pkg::MIN_LENGTH);
		end else if (len_ext > LW'(TABLE_DEPTH)) begin
			len_clamp = LW'(TABLE_DEPTH);
		end else begin
			len_clamp = len_ext;
		end
		last_full = len_clamp - LW'(1);
	end
	assign last_idx = last_full[AW-1:0];

	// table writes come straight from a load transfer; out-of-range index is dropped
	assign ram_we = accept && (request.command == tli_pkg::CMD_LOAD)
		&& (LW'(request.entry_index) < LW'(TABLE_DEPTH));
	assign ram_waddr = AW'(request.entry_index);
	assign ram_wdata = '{x: request.entry_x, y: request.entry_y};

	tli_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// scan: read data is entry i_q; stop at first x not below input or at the last entry
	assign scan_stop = (ram_rdata.x >= xv_q) || (i_q == last_idx);
	assign dx_c = $signed({1'b0, ram_rdata.x}) - $signed({1'b0, x0_q});
	assign xd_c = $signed({1'b0, xv_q}) - $signed({1'b0, x0_q});
	assign dy_c = $signed({ram_rdata.y[YW-1], ram_rdata.y}) - $signed({y0_q[YW-1], y0_q});
	assign dx_zero = (dx_c == '0);

	// numerator y0*dx + dy*xd, msb first over the bits of dx and xd
	// top bit carries negative weight (two's complement), so the first step subtracts
	assign term_y0 = dx_sh_q[DXW-1] ? TW'(y0_q) : '0;
	assign term_dy = xd_sh_q[DXW-1] ? TW'(dy_q) : '0;
	assign term = term_y0 + term_dy;
	assign acc_d = (bit_cnt_q == CNT_W'(MUL_STEPS - 1)) ? -(PW'(term))
		: (acc_q <<< 1) + PW'(term);

	// divider works on magnitudes, sign is put back afterwards
	assign div_dividend = acc_q[PW-1] ? PW'(-acc_q) : PW'(acc_q);
	assign div_divisor = dx_q[DXW-1] ? XW'(-dx_q) : XW'(dx_q);

	tli_div #(
		.NW(PW),
		.DW(XW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quotient)
	);

	// truncated quotient, signed and saturated to 16 bits
	always_comb begin
		res_neg = acc_q[PW-1] ^ dx_q[DXW-1];
		res_div.saturated = 1'b0;
		if (!res_neg) begin
			if (div_quotient > PW'(tli_pkg::TEMP_POS_LIMIT)) begin
				res_div.saturated = 1'b1;
				res_div.temperature = YW'(tli_pkg::TEMP_POS_LIMIT);
			end else begin
				res_div.temperature = div_quotient[YW-1:0];
			end
		end else begin
			if (div_quotient > PW'(tli_pkg::TEMP_NEG_LIMIT)) begin
				res_div.saturated = 1'b1;
				res_div.temperature = YW'(tli_pkg::TEMP_NEG_LIMIT);
			end else begin
				res_div.temperature = ~div_quotient[YW-1:0] + YW'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tli_pkg::ST_IDLE: begin
				if (accept && (request.command == tli_pkg::CMD_CONVERT)) begin
					state_d = tli_pkg::ST_FIRST;
				end
			end
			tli_pkg::ST_FIRST: begin
				state_d = tli_pkg::ST_SCAN;
			end
			tli_pkg::ST_SCAN: begin
				if (scan_stop) begin
					state_d = dx_zero ? tli_pkg::ST_IDLE : tli_pkg::ST_MUL;
				end
			end
			tli_pkg::ST_MUL: begin
				if (bit_cnt_q == '0) begin
					state_d = tli_pkg::ST_DIVGO;
				end
			end
			tli_pkg::ST_DIVGO: begin
				state_d = tli_pkg::ST_DIV;
			end
			tli_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = tli_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tli_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs: table read address, divider kick, handshakes
	always_comb begin
		ram_raddr = '0;
		div_start = 1'b0;
		case (state_q)
			tli_pkg::ST_FIRST: begin
				ram_raddr = AW'(1);
			end
			tli_pkg::ST_SCAN: begin
				ram_raddr = i_q + AW'(1);
			end
			tli_pkg::ST_DIVGO: begin
				div_start = 1'b1;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
		busy = (state_q != tli_pkg::ST_IDLE);
		cfg_ready = (state_q == tli_pkg::ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tli_pkg::ST_IDLE;
			table_length_q <= tli_pkg::TABLE_LENGTH_RST;
			i_q <= '0;
			bit_cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= ((state_q == tli_pkg::ST_SCAN) && scan_stop && dx_zero)
				|| ((state_q == tli_pkg::ST_DIV) && div_done);
			if (cfg_valid && cfg_ready) begin
				table_length_q <= cfg_data;
			end
			if (state_q == tli_pkg::ST_FIRST) begin
				i_q <= AW'(1);
			end else if ((state_q == tli_pkg::ST_SCAN) && !scan_stop) begin
				i_q <= i_q + AW'(1);
			end
			if (state_q == tli_pkg::ST_SCAN) begin
				bit_cnt_q <= CNT_W'(MUL_STEPS - 1);
			end else if (state_q == tli_pkg::ST_MUL) begin
				bit_cnt_q <= bit_cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xv_q <= request.measured_resistance;
		end
		case (state_q)
			tli_pkg::ST_FIRST: begin
				x0_q <= ram_rdata.x;
				y0_q <= ram_rdata.y;
			end
			tli_pkg::ST_SCAN: begin
				if (!scan_stop) begin
					// slide the lower breakpoint up
					x0_q <= ram_rdata.x;
					y0_q <= ram_rdata.y;
				end else if (dx_zero) begin
					result_q.temperature <= y0_q;
					result_q.saturated <= 1'b0;
				end else begin
					dx_q <= dx_c;
					dy_q <= dy_c;
					dx_sh_q <= dx_c;
					xd_sh_q <= xd_c;
				end
			end
			tli_pkg::ST_MUL: begin
				acc_q <= acc_d;
				dx_sh_q <= {dx_sh_q[DXW-2:0], 1'b0};
				xd_sh_q <= {xd_sh_q[DXW-2:0], 1'b0};
			end
			tli_pkg::ST_DIV: begin
				if (div_done) begin
					result_q <= res_div;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign done = done_q;
	assign result = result_q;

	`TLI_ASSERT(a_done_one_cycle, done_q |=> !done_q)
	`TLI_ASSERT(a_done_when_idle, done_q |-> !busy)
	`TLI_ASSERT(a_load_stays_idle, (accept && (request.command == tli_pkg::CMD_LOAD)) |=> !busy)
	`TLI_ASSERT(a_convert_goes_busy, (accept && (request.command == tli_pkg::CMD_CONVERT)) |=> busy)
	`TLI_ASSERT(a_scan_in_bounds, (state_q == tli_pkg::ST_SCAN) |-> (i_q <= last_idx))

endmodule

`default_nettype wire
